### rtl/core/fchp_pkg.sv
package fchp_pkg;

  localparam logic [7:0] StartByte = 8'hAA;
  localparam logic [7:0] EndByte   = 8'h55;
  localparam logic [7:0] PingByte  = 8'hCC;

  localparam logic [7:0] CmdSetScore = 8'h01;
  localparam logic [7:0] CmdSetTimer = 8'h02;
  localparam logic [7:0] CmdStart    = 8'h03;
  localparam logic [7:0] CmdStop     = 8'h04;
  localparam logic [7:0] CmdReset    = 8'h05;
  localparam logic [7:0] CmdPing     = 8'h06;
  localparam logic [7:0] CmdSetLed   = 8'h07;

  localparam logic [7:0] SelRed  = 8'h01;
  localparam logic [7:0] SelBlue = 8'h02;

  localparam logic [2:0] StAbsorbed = 3'd0;
  localparam logic [2:0] StExecuted = 3'd1;
  localparam logic [2:0] StBadStart = 3'd2;
  localparam logic [2:0] StTooLong  = 3'd3;
  localparam logic [2:0] StBadEnd   = 3'd4;
  localparam logic [2:0] StBadSum   = 3'd5;

  localparam logic [1:0] RegMaxPayload   = 2'd0;
  localparam logic [1:0] RegResetMinutes = 2'd1;
  localparam logic [1:0] RegResetSeconds = 2'd2;

  localparam logic [7:0] MaxPayloadRst   = 8'd10;
  localparam logic [7:0] ResetMinutesRst = 8'd2;
  localparam logic [7:0] ResetSecondsRst = 8'd30;

  localparam int unsigned AddrWidth = 4;

  typedef struct packed {
    logic [7:0] max_payload;
    logic [7:0] reset_minutes;
    logic [7:0] reset_seconds;
  } cfg_t;

  // one record per accepted byte, expanded to one or three results
  typedef struct packed {
    logic       ping;
    logic [2:0] packet_status;
    logic [7:0] minutes_shown;
    logic [7:0] seconds_shown;
    logic [7:0] red_points;
    logic [7:0] blue_points;
    logic       red_lamp;
    logic       blue_lamp;
  } rec_t;

endpackage

### rtl/core/fchp_if.sv
interface fchp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface fchp_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_valid;
  logic       last;
  logic [2:0] packet_status;
  logic [7:0] minutes_shown;
  logic [7:0] seconds_shown;
  logic [7:0] red_points;
  logic [7:0] blue_points;
  logic       red_lamp;
  logic       blue_lamp;

  modport source (output valid, output tx_byte, output tx_valid, output last,
                  output packet_status, output minutes_shown, output seconds_shown,
                  output red_points, output blue_points, output red_lamp,
                  output blue_lamp, input ready);
  modport sink (input valid, input tx_byte, input tx_valid, input last,
                input packet_status, input minutes_shown, input seconds_shown,
                input red_points, input blue_points, input red_lamp,
                input blue_lamp, output ready);
endinterface

### rtl/core/framed_command_packet_handler.sv
// Deframes packets of start byte 0xAA, command, length, payload, XOR checksum
// and end byte 0x55 from one received byte per request, and reports for every
// byte one result with the packet status, timer, scores and gated LED levels;
// a valid ping packet gives three results carrying the reply 0xAA, 0xCC, 0x55.
// Each byte is parsed and its command executed in the cycle it is accepted, so
// one byte per clock is taken; results pass through a two-entry queue, and the
// input stalls only while that queue is full (a ping holds its entry until all
// three reply bytes are taken). Configuration goes through the APB port at
// byte addresses 0 (max payload), 4 (reset minutes) and 8 (reset seconds).
module framed_command_packet_handler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fchp_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  fchp_rx_if.sink                        rx_i,
  fchp_res_if.source                     res_o
);
  import fchp_pkg::*;

  cfg_t cfg;
  rec_t rec;
  logic space;
  logic take;

  assign rx_i.ready = space;
  assign take       = rx_i.valid && space;

  fchp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fchp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .take_i    (take),
    .rx_byte_i (rx_i.rx_byte),
    .rec_o     (rec)
  );

  fchp_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .rec_i   (rec),
    .space_o (space),
    .res_o   (res_o)
  );

endmodule

### rtl/core/fchp_cfg.sv
module fchp_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fchp_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output fchp_pkg::cfg_t                 cfg_o
);
  import fchp_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] idx;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_payload   <= MaxPayloadRst;
      cfg_q.reset_minutes <= ResetMinutesRst;
      cfg_q.reset_seconds <= ResetSecondsRst;
    end else if (wr_en) begin
      unique case (idx)
        RegMaxPayload:   cfg_q.max_payload   <= pwdata[7:0];
        RegResetMinutes: cfg_q.reset_minutes <= pwdata[7:0];
        RegResetSeconds: cfg_q.reset_seconds <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegMaxPayload:   prdata = {24'd0, cfg_q.max_payload};
      RegResetMinutes: prdata = {24'd0, cfg_q.reset_minutes};
      RegResetSeconds: prdata = {24'd0, cfg_q.reset_seconds};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

### rtl/core/fchp_parser.sv
module fchp_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fchp_pkg::cfg_t cfg_i,
  input  logic           take_i,
  input  logic [7:0]     rx_byte_i,
  output fchp_pkg::rec_t rec_o
);
  import fchp_pkg::*;

  localparam logic [2:0] PhHunt = 3'd0;
  localparam logic [2:0] PhCmd  = 3'd1;
  localparam logic [2:0] PhLen  = 3'd2;
  localparam logic [2:0] PhData = 3'd3;
  localparam logic [2:0] PhSum  = 3'd4;
  localparam logic [2:0] PhEnd  = 3'd5;

  logic [2:0] phase_q, phase_d;
  logic [7:0] cmd_q, cmd_d, len_q, len_d, cnt_q, cnt_d, xor_q, xor_d;
  logic [7:0] p1_q, p1_d, p2_q, p2_d, sum_q, sum_d;
  logic [7:0] min_q, min_d, sec_q, sec_d, red_q, red_d, blue_q, blue_d;
  logic       run_q, run_d, rflag_q, rflag_d, bflag_q, bflag_d;
  logic [2:0] status;
  logic       ping;
  logic       two;
  logic [8:0] cnt_inc;

  assign two     = len_q >= 8'd2;
  assign cnt_inc = {1'b0, cnt_q} + 9'd1;

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    xor_d   = xor_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    sum_d   = sum_q;
    min_d   = min_q;
    sec_d   = sec_q;
    red_d   = red_q;
    blue_d  = blue_q;
    run_d   = run_q;
    rflag_d = rflag_q;
    bflag_d = bflag_q;
    status  = StAbsorbed;
    ping    = 1'b0;
    unique case (phase_q)
      PhCmd: begin
        cmd_d   = rx_byte_i;
        xor_d   = rx_byte_i;
        phase_d = PhLen;
      end
      PhLen: begin
        if (rx_byte_i > cfg_i.max_payload) begin
          status  = StTooLong;
          phase_d = PhHunt;
        end else begin
          len_d   = rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          cnt_d   = 8'd0;
          phase_d = (rx_byte_i == 8'd0) ? PhSum : PhData;
        end
      end
      PhData: begin
        if (cnt_q == 8'd0) p1_d = rx_byte_i;
        else if (cnt_q == 8'd1) p2_d = rx_byte_i;
        xor_d = xor_q ^ rx_byte_i;
        cnt_d = cnt_inc[7:0];
        if (cnt_inc >= {1'b0, len_q}) phase_d = PhSum;
      end
      PhSum: begin
        sum_d   = rx_byte_i;
        phase_d = PhEnd;
      end
      PhEnd: begin
        phase_d = PhHunt;
        if (rx_byte_i != EndByte) begin
          status = StBadEnd;
        end else if (sum_q != xor_q) begin
          status = StBadSum;
        end else begin
          status = StExecuted;
          unique case (cmd_q)
            CmdSetScore: begin
              if (two) begin
                red_d  = p1_q;
                blue_d = p2_q;
              end
            end
            CmdSetTimer: begin
              if (two) begin
                min_d = p1_q;
                sec_d = p2_q;
              end
            end
            CmdStart: begin
              run_d   = 1'b1;
              rflag_d = 1'b1;
              bflag_d = 1'b1;
            end
            CmdStop: begin
              run_d   = 1'b0;
              rflag_d = 1'b0;
              bflag_d = 1'b0;
            end
            CmdReset: begin
              min_d  = cfg_i.reset_minutes;
              sec_d  = cfg_i.reset_seconds;
              red_d  = 8'd0;
              blue_d = 8'd0;
              run_d  = 1'b0;
            end
            CmdPing: ping = 1'b1;
            CmdSetLed: begin
              if (two) begin
                if (p1_q == SelRed) rflag_d = (p2_q != 8'd0);
                else if (p1_q == SelBlue) bflag_d = (p2_q != 8'd0);
              end
            end
            default: ;
          endcase
        end
      end
      default: begin
        if (rx_byte_i == StartByte) begin
          phase_d = PhCmd;
        end else begin
          phase_d = PhHunt;
          status  = StBadStart;
        end
      end
    endcase
  end

  // record carries the values as they stand after this byte
  always_comb begin
    rec_o.ping          = ping;
    rec_o.packet_status = status;
    rec_o.minutes_shown = min_d;
    rec_o.seconds_shown = sec_d;
    rec_o.red_points    = red_d;
    rec_o.blue_points   = blue_d;
    rec_o.red_lamp      = run_d & rflag_d;
    rec_o.blue_lamp     = run_d & bflag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      cmd_q   <= 8'd0;
      len_q   <= 8'd0;
      cnt_q   <= 8'd0;
      xor_q   <= 8'd0;
      p1_q    <= 8'd0;
      p2_q    <= 8'd0;
      sum_q   <= 8'd0;
      min_q   <= ResetMinutesRst;
      sec_q   <= ResetSecondsRst;
      red_q   <= 8'd0;
      blue_q  <= 8'd0;
      run_q   <= 1'b0;
      rflag_q <= 1'b0;
      bflag_q <= 1'b0;
    end else if (take_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      xor_q   <= xor_d;
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      sum_q   <= sum_d;
      min_q   <= min_d;
      sec_q   <= sec_d;
      red_q   <= red_d;
      blue_q  <= blue_d;
      run_q   <= run_d;
      rflag_q <= rflag_d;
      bflag_q <= bflag_d;
    end
  end

endmodule

### rtl/core/fchp_out.sv
module fchp_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fchp_pkg::rec_t rec_i,
  output logic           space_o,
  fchp_res_if.source     res_o
);
  import fchp_pkg::*;

  rec_t       buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic [1:0] beat_q;
  rec_t       head;
  logic       last_beat;
  logic       pop;

  assign head      = buf_q[rd_q];
  assign last_beat = !head.ping || (beat_q == 2'd2);
  assign pop       = res_o.valid && res_o.ready && last_beat;
  assign space_o   = (cnt_q != 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      cnt_q  <= 2'd0;
      beat_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
      if (pop) beat_q <= 2'd0;
      else if (res_o.valid && res_o.ready) beat_q <= beat_q + 2'd1;
    end
  end

  always_comb begin
    res_o.valid         = (cnt_q != 2'd0);
    res_o.tx_valid      = head.ping;
    res_o.last          = last_beat;
    res_o.packet_status = head.packet_status;
    res_o.minutes_shown = head.minutes_shown;
    res_o.seconds_shown = head.seconds_shown;
    res_o.red_points    = head.red_points;
    res_o.blue_points   = head.blue_points;
    res_o.red_lamp      = head.red_lamp;
    res_o.blue_lamp     = head.blue_lamp;
    if (!head.ping) begin
      res_o.tx_byte = 8'd0;
    end else begin
      case (beat_q)
        2'd0:    res_o.tx_byte = StartByte;
        2'd1:    res_o.tx_byte = PingByte;
        default: res_o.tx_byte = EndByte;
      endcase
    end
  end

endmodule

### bench/tb_framed_command_packet_handler.sv
`timescale 1ns / 1ps

module tb_framed_command_packet_handler;
  import fchp_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 200;

  typedef enum logic [2:0] {PhHunt, PhCmd, PhLen, PhData, PhSum, PhEnd} phase_e;
  typedef enum int {FrOk, FrBadEnd, FrBadSum, FrTooLong} frame_fault_e;

  typedef struct {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       last;
    logic [2:0] status;
    logic [7:0] minutes;
    logic [7:0] seconds;
    logic [7:0] red;
    logic [7:0] blue;
    logic       red_lamp;
    logic       blue_lamp;
  } result_t;

  // tracks the deframer and match state, and holds the results still due
  class frame_checker;
    logic [7:0] max_len, rst_min, rst_sec;
    phase_e     parse;
    logic [7:0] cmd_q, len_q, count, xor_q, p0, p1, sum_q;
    logic [7:0] t_min, t_sec, red, blue;
    logic       running, red_flag, blue_flag;
    result_t    awaited[$];
    int         errors;

    function new();
      max_len = MaxPayloadRst;
      rst_min = ResetMinutesRst;
      rst_sec = ResetSecondsRst;
      parse = PhHunt;
      cmd_q = 0; len_q = 0; count = 0; xor_q = 0; p0 = 0; p1 = 0; sum_q = 0;
      t_min = ResetMinutesRst;
      t_sec = ResetSecondsRst;
      red = 0; blue = 0;
      running = 0; red_flag = 0; blue_flag = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] v);
      case (idx)
        RegMaxPayload:   max_len = v;
        RegResetMinutes: rst_min = v;
        RegResetSeconds: rst_sec = v;
        default: ;
      endcase
    endfunction

    function void push(logic [7:0] tx, logic txv, logic lst, logic [2:0] st);
      result_t r;
      r.tx_byte = tx;
      r.tx_valid = txv;
      r.last = lst;
      r.status = st;
      r.minutes = t_min;
      r.seconds = t_sec;
      r.red = red;
      r.blue = blue;
      r.red_lamp = running & red_flag;
      r.blue_lamp = running & blue_flag;
      awaited.push_back(r);
    endfunction

    // returns 1 for a ping, which answers with three bytes
    function bit run_cmd();
      bit two;
      two = (len_q >= 8'd2);
      case (cmd_q)
        CmdSetScore: if (two) begin
          red = p0;
          blue = p1;
        end
        CmdSetTimer: if (two) begin
          t_min = p0;
          t_sec = p1;
        end
        CmdStart: begin
          running = 1; red_flag = 1; blue_flag = 1;
        end
        CmdStop: begin
          running = 0; red_flag = 0; blue_flag = 0;
        end
        CmdReset: begin
          t_min = rst_min; t_sec = rst_sec;
          red = 0; blue = 0; running = 0;
        end
        CmdPing: return 1'b1;
        CmdSetLed: if (two) begin
          if (p0 == SelRed) red_flag = (p1 != 0);
          else if (p0 == SelBlue) blue_flag = (p1 != 0);
        end
        default: ;
      endcase
      return 1'b0;
    endfunction

    function void note_byte(logic [7:0] b);
      logic [2:0] st;
      st = StAbsorbed;
      case (parse)
        PhCmd: begin
          cmd_q = b;
          xor_q = b;
          parse = PhLen;
        end
        PhLen: begin
          if (b > max_len) begin
            st = StTooLong;
            parse = PhHunt;
          end else begin
            len_q = b;
            xor_q ^= b;
            count = 0;
            parse = (b == 0) ? PhSum : PhData;
          end
        end
        PhData: begin
          if (count == 0) p0 = b;
          else if (count == 1) p1 = b;
          xor_q ^= b;
          count = count + 8'd1;
          if (count >= len_q) parse = PhSum;
        end
        PhSum: begin
          sum_q = b;
          parse = PhEnd;
        end
        PhEnd: begin
          parse = PhHunt;
          if (b != EndByte) st = StBadEnd;
          else if (sum_q != xor_q) st = StBadSum;
          else if (run_cmd()) begin
            push(StartByte, 1'b1, 1'b0, StExecuted);
            push(PingByte, 1'b1, 1'b0, StExecuted);
            push(EndByte, 1'b1, 1'b1, StExecuted);
            return;
          end else st = StExecuted;
        end
        default: begin
          parse = PhHunt;
          if (b == StartByte) parse = PhCmd;
          else st = StBadStart;
        end
      endcase
      push(8'h00, 1'b0, 1'b1, st);
    endfunction

    function void cmp_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t w;
      if (awaited.size() == 0) begin
        $error("result with nothing due: tx_byte %0h status %0d", got.tx_byte, got.status);
        errors++;
        return;
      end
      w = awaited.pop_front();
      cmp_field("tx_byte", w.tx_byte, got.tx_byte);
      cmp_field("tx_valid", w.tx_valid, got.tx_valid);
      cmp_field("last", w.last, got.last);
      cmp_field("packet_status", w.status, got.status);
      cmp_field("minutes_shown", w.minutes, got.minutes);
      cmp_field("seconds_shown", w.seconds, got.seconds);
      cmp_field("red_points", w.red, got.red);
      cmp_field("blue_points", w.blue, got.blue);
      cmp_field("red_lamp", w.red_lamp, got.red_lamp);
      cmp_field("blue_lamp", w.blue_lamp, got.blue_lamp);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 psel, penable, pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  fchp_rx_if  rx_if ();
  fchp_res_if res_if ();

  framed_command_packet_handler u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rx_i    (rx_if),
    .res_o   (res_if)
  );

  frame_checker chk = new();
  logic [7:0]   stream[$];
  int           quiet_cycles = 0;
  bit           hold_go = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin : monitor
    result_t got;
    bit moved;
    moved = 1'b0;
    if (rx_if.valid === 1'b1 && rx_if.ready === 1'b1) begin
      chk.note_byte(rx_if.rx_byte);
      moved = 1'b1;
    end
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got.tx_byte = res_if.tx_byte;
      got.tx_valid = res_if.tx_valid;
      got.last = res_if.last;
      got.status = res_if.packet_status;
      got.minutes = res_if.minutes_shown;
      got.seconds = res_if.seconds_shown;
      got.red = res_if.red_points;
      got.blue = res_if.blue_points;
      got.red_lamp = res_if.red_lamp;
      got.blue_lamp = res_if.blue_lamp;
      chk.check_result(got);
      moved = 1'b1;
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QuietLimit) @(posedge clk);
    $display("tb_framed_command_packet_handler: errors");
    $finish;
  end

  // result side: rotating stall patterns, plus a long hold-off on request
  initial begin : receiver
    int cyc;
    cyc = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_go) begin
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_go = 1'b0;
      end else begin
        case ((cyc / 97) % 4)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= 1'($urandom_range(0, 1));
          2: res_if.ready <= ($urandom_range(0, 3) == 0);
          default: res_if.ready <= ((cyc % 5) < 2);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (rx_if.ready !== 1'b1);
  endtask

  task automatic send_stream();
    int burst, gap;
    while (stream.size() != 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && stream.size() != 0) begin
        send_byte(stream.pop_front());
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        rx_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    rx_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (chk.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write one register, then read it back
  task automatic reg_write(input logic [1:0] idx, input logic [7:0] v);
    logic [31:0] got;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    chk.set_reg(idx, v);
    if (got !== {24'd0, v}) begin
      $error("prdata: expected %0h, got %0h", v, got);
      chk.errors++;
    end
  endtask

  task automatic frame(input logic [7:0] cmd, input int len, input logic [7:0] b0,
                       input logic [7:0] b1, input frame_fault_e fault);
    logic [7:0] sum, pb, tail;
    frame_fault_e f;
    f = fault;
    if (f == FrTooLong && chk.max_len == 8'hFF) f = FrBadEnd;
    stream.push_back(StartByte);
    stream.push_back(cmd);
    if (f == FrTooLong) begin
      stream.push_back(8'($urandom_range(int'(chk.max_len) + 1, 255)));
      return;
    end
    stream.push_back(len[7:0]);
    sum = cmd ^ len[7:0];
    for (int i = 0; i < len; i++) begin
      pb = (i == 0) ? b0 : (i == 1) ? b1 : 8'($urandom);
      sum ^= pb;
      stream.push_back(pb);
    end
    stream.push_back((f == FrBadSum) ? (sum ^ 8'($urandom_range(1, 255))) : sum);
    tail = 8'($urandom);
    if (tail == EndByte) tail = ~tail;
    stream.push_back((f == FrBadEnd) ? tail : EndByte);
  endtask

  // mostly well-formed packets with random content, some broken ones and stray bytes
  task automatic rand_packets(input int n_bytes);
    logic [7:0] cmd, b0, b1;
    int pick, len, cap, r;
    frame_fault_e f;
    while (stream.size() < n_bytes) begin
      pick = $urandom_range(0, 99);
      cap = chk.max_len;
      if (pick < 8) begin
        stream.push_back(8'($urandom));
      end else begin
        r = $urandom_range(0, 8);
        if (r <= 6) cmd = 8'(r + 1);
        else if (r == 7) cmd = 8'($urandom);
        else cmd = CmdSetLed;
        r = $urandom_range(0, 9);
        if (r <= 5) len = 2;
        else if (r == 6) len = 0;
        else if (r == 7) len = 1;
        else if (r == 8) len = $urandom_range(0, 4);
        else len = $urandom_range(0, cap);
        if (len > cap) len = cap;
        if (cmd == CmdSetLed) begin
          b0 = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 2)) : 8'($urandom);
          b1 = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'($urandom);
        end else begin
          b0 = 8'($urandom);
          b1 = 8'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 82) f = FrOk;
        else if (r < 88) f = FrBadEnd;
        else if (r < 94) f = FrBadSum;
        else f = FrTooLong;
        frame(cmd, len, b0, b1, f);
      end
    end
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = 8'h00;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed packets under the reset settings
    stream.push_back(8'h00);
    stream.push_back(8'hFF);
    frame(CmdSetScore, 2, 8'hFF, 8'h00, FrOk);
    frame(CmdSetTimer, 2, 8'h00, 8'hFF, FrOk);
    frame(CmdStart, 0, 8'h00, 8'h00, FrOk);
    frame(CmdSetLed, 2, SelRed, 8'h00, FrOk);
    // start byte in the payload is plain data
    frame(CmdSetLed, 2, SelBlue, StartByte, FrOk);
    frame(CmdSetLed, 2, 8'h03, 8'h01, FrOk);
    frame(CmdSetScore, 1, 8'h12, 8'h00, FrOk);
    frame(CmdPing, 0, 8'h00, 8'h00, FrOk);
    frame(8'h08, 0, 8'h00, 8'h00, FrOk);
    frame(CmdSetScore, 2, 8'h01, 8'h02, FrTooLong);
    frame(CmdSetTimer, 2, 8'h03, 8'h04, FrBadEnd);
    frame(CmdSetScore, 2, 8'h05, 8'h06, FrBadSum);
    frame(CmdStop, 10, 8'h01, 8'h01, FrOk);
    frame(CmdReset, 0, 8'h00, 8'h00, FrOk);
    send_stream();
    wait_drained();

    // widest settings, with the receiver holding off at the start
    reg_write(RegMaxPayload, 8'hFF);
    reg_write(RegResetMinutes, 8'hFF);
    reg_write(RegResetSeconds, 8'hFF);
    hold_go = 1'b1;
    rand_packets(96);
    send_stream();
    wait_drained();

    reg_write(RegMaxPayload, 8'h00);
    reg_write(RegResetMinutes, 8'h00);
    reg_write(RegResetSeconds, 8'h00);
    rand_packets(96);
    send_stream();
    wait_drained();

    reg_write(RegMaxPayload, 8'($urandom_range(1, 12)));
    reg_write(RegResetMinutes, 8'($urandom));
    reg_write(RegResetSeconds, 8'($urandom));
    rand_packets(96);
    send_stream();
    wait_drained();

    reg_write(RegMaxPayload, 8'($urandom_range(2, 6)));
    reg_write(RegResetMinutes, 8'($urandom));
    reg_write(RegResetSeconds, 8'($urandom));
    hold_go = 1'b1;
    rand_packets(96);
    send_stream();
    wait_drained();
    repeat (20) @(posedge clk);

    if (chk.errors == 0 && chk.awaited.size() == 0) begin
      $display("tb_framed_command_packet_handler: clean");
    end else begin
      $display("tb_framed_command_packet_handler: errors");
    end
    $finish;
  end

endmodule
